// File: rtl/rsrn_pkg.sv
// Shared constants, command/status types and codes for the residual
// scale/rotate/norm block. No dependencies.
package rsrn_pkg;

    // fixed field widths
    localparam int TC_W       = 9;
    localparam int SQS_W      = 17;
    localparam int NORM_W     = 63;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // shared divider widths
    localparam int DIV_W   = 64;
    localparam int DVS_W   = 34;
    localparam int CNT_W   = 7;
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);

    // 1/sqrt2 in Q0.32
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
    localparam logic [63:0] SUM_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TOROIDAL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_Z   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INCL     = 3'd5;

    // divider jobs
    localparam logic [1:0] OP_MODE  = 2'd0;
    localparam logic [1:0] OP_SCALE = 2'd1;
    localparam logic [1:0] OP_NORM  = 2'd2;

    // multiplier jobs
    localparam logic [1:0] MUL_NONE   = 2'd0;
    localparam logic [1:0] MUL_ROT_LO = 2'd1;
    localparam logic [1:0] MUL_ROT_HI = 2'd2;
    localparam logic [1:0] MUL_SQ     = 2'd3;

    typedef struct packed {
        logic       in_load;
        logic       div_start;
        logic       div_wr;
        logic [1:0] op;
        logic [2:0] idx;
        logic       rot_load;
        logic [1:0] mul;
        logic       rot_wr;
        logic       sq_acc;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic m_odd;
        logic m_one;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/rsrn_if.sv
// Channel interfaces: configuration writes, input points, results.
// Depends on rsrn_pkg.
interface rsrn_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rsrn_pkg::CFG_ADDR_W-1:0]   addr;
    logic [rsrn_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

interface rsrn_in_if #(
    parameter int MODE_W = 10,
    parameter int SURF_W = 10,
    parameter int CW     = 32
);
    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode_index;
    logic [SURF_W-1:0]            surface_index;
    logic [rsrn_pkg::SQS_W-1:0]   sqrt_s;
    logic signed [CW-1:0]         comp_0;
    logic signed [CW-1:0]         comp_1;
    logic signed [CW-1:0]         comp_2;
    logic signed [CW-1:0]         comp_3;
    logic signed [CW-1:0]         comp_4;
    logic signed [CW-1:0]         comp_5;
    logic                         last_point;
    modport source (output valid, mode_index, surface_index, sqrt_s, comp_0, comp_1,
                    comp_2, comp_3, comp_4, comp_5, last_point, input ready);
    modport sink   (input valid, mode_index, surface_index, sqrt_s, comp_0, comp_1,
                    comp_2, comp_3, comp_4, comp_5, last_point, output ready);
endinterface

interface rsrn_out_if #(
    parameter int CW = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [CW-1:0]          res_0;
    logic signed [CW-1:0]          res_1;
    logic signed [CW-1:0]          res_2;
    logic signed [CW-1:0]          res_3;
    logic signed [CW-1:0]          res_4;
    logic signed [CW-1:0]          res_5;
    logic [rsrn_pkg::NORM_W-1:0]   norm_a;
    logic [rsrn_pkg::NORM_W-1:0]   norm_b;
    logic [rsrn_pkg::NORM_W-1:0]   norm_c;
    logic                          is_last;
    modport source (output valid, res_0, res_1, res_2, res_3, res_4, res_5,
                    norm_a, norm_b, norm_c, is_last, input ready);
    modport sink   (input valid, res_0, res_1, res_2, res_3, res_4, res_5,
                    norm_a, norm_b, norm_c, is_last, output ready);
endinterface

// File: rtl/residual_scale_rotate_norm_core.sv
// Residual rescaler with rotation and running mean-square norms.
// Top level; depends on rsrn_pkg, rsrn_if, rsrn_ctrl, rsrn_dp.
//
// Usage:
//   i_cfg : register writes (addr, data), always ready; write only while idle.
//   i_in  : one spectral point per transfer (mode, surface, sqrt_s, six
//           components, last-point flag).
//   o_out : one result per point: six transformed components, and on the
//           last point the three mean squares with is_last set.
// Timing: one point at a time. Every division runs on one shared radix-2
//   divider. The next point can be taken in the cycle after a result is
//   loaded into the output register; odd m adds six scaling divisions, m
//   equal to one adds rotation on the shared multiplier, and the last point
//   adds three norm divisions.
// Reset: synchronous, active low; config returns to defaults, sums clear.
// Stall: the result sits in an output register; the next point is taken
//   while it waits, and the block holds before its next result until the
//   register frees.
module residual_scale_rotate_norm_core #(
    parameter int MAX_SURFACES   = 1024,
    parameter int MAX_MODES      = 1024,
    parameter int COMPONENT_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsrn_cfg_if.sink     i_cfg,
    rsrn_in_if.sink      i_in,
    rsrn_out_if.source   o_out
);
    localparam int MODE_W = $clog2(MAX_MODES);
    localparam int SURF_W = $clog2(MAX_SURFACES);
    localparam int TP_W   = $clog2(longint'(MAX_MODES) * longint'(MAX_SURFACES)) + 1;

    rsrn_pkg::t_cmd cmd;
    rsrn_pkg::t_sts sts;

    logic signed [COMPONENT_BITS-1:0] comp [6];
    logic signed [COMPONENT_BITS-1:0] res [6];
    logic [rsrn_pkg::NORM_W-1:0]      norm [3];

    // gather components
    assign comp[0] = i_in.comp_0;
    assign comp[1] = i_in.comp_1;
    assign comp[2] = i_in.comp_2;
    assign comp[3] = i_in.comp_3;
    assign comp[4] = i_in.comp_4;
    assign comp[5] = i_in.comp_5;

    rsrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsrn_dp #(
        .MODE_W (MODE_W),
        .SURF_W (SURF_W),
        .TP_W   (TP_W),
        .CW     (COMPONENT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg.valid),
        .o_cfg_ready     (i_cfg.ready),
        .i_cfg_addr      (i_cfg.addr),
        .i_cfg_data      (i_cfg.data),
        .i_mode_index    (i_in.mode_index),
        .i_surface_index (i_in.surface_index),
        .i_sqrt_s        (i_in.sqrt_s),
        .i_comp          (comp),
        .i_last_point    (i_in.last_point),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_res           (res),
        .o_norm          (norm),
        .o_is_last       (o_out.is_last)
    );

    // scatter results
    assign o_out.res_0  = res[0];
    assign o_out.res_1  = res[1];
    assign o_out.res_2  = res[2];
    assign o_out.res_3  = res[3];
    assign o_out.res_4  = res[4];
    assign o_out.res_5  = res[5];
    assign o_out.norm_a = norm[0];
    assign o_out.norm_b = norm[1];
    assign o_out.norm_c = norm[2];
endmodule

// File: rtl/rsrn_div.sv
// Restoring divider, one quotient bit per cycle (64 steps).
// Depends on rsrn_pkg.
module rsrn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rsrn_pkg::DIV_W-1:0]    i_dividend,
    input  logic [rsrn_pkg::DVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [rsrn_pkg::DIV_W-1:0]    o_quo,
    output logic [rsrn_pkg::DVS_W-1:0]    o_rem
);
    logic [rsrn_pkg::DIV_W-1:0] r_quo;
    logic [rsrn_pkg::DVS_W-1:0] r_rem;
    logic [rsrn_pkg::DVS_W-1:0] r_dvs;
    logic [rsrn_pkg::CNT_W-1:0] r_cnt;
    logic                       r_done;

    logic [rsrn_pkg::DVS_W:0]   shifted;
    logic                       ge;
    logic [rsrn_pkg::DVS_W:0]   diff;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_quo[rsrn_pkg::DIV_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    // control: step counter and finish flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= rsrn_pkg::DIV_STEPS;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == rsrn_pkg::CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[rsrn_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[rsrn_pkg::DVS_W-1:0] : shifted[rsrn_pkg::DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// File: rtl/rsrn_dp.sv
// Datapath: config registers, point registers, shared divider and
// multiplier, square-sum accumulators, output register. Uses rsrn_pkg, rsrn_div.
module rsrn_dp #(
    parameter int MODE_W = 10,
    parameter int SURF_W = 10,
    parameter int TP_W   = 21,
    parameter int CW     = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rsrn_pkg::t_cmd                     i_cmd,
    output rsrn_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rsrn_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rsrn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [MODE_W-1:0]                  i_mode_index,
    input  logic [SURF_W-1:0]                  i_surface_index,
    input  logic [rsrn_pkg::SQS_W-1:0]         i_sqrt_s,
    input  logic signed [CW-1:0]               i_comp [6],
    input  logic                               i_last_point,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [CW-1:0]               o_res [6],
    output logic [rsrn_pkg::NORM_W-1:0]        o_norm [3],
    output logic                               o_is_last
);
    // magnitude of a component
    function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] x);
        logic [CW-1:0] u;
        u = x;
        return x[CW-1] ? (~u + 1'b1) : u;
    endfunction

    // signed saturation of a magnitude to CW bits
    function automatic logic signed [CW-1:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [64:0]   lim;
        logic [CW-1:0] t;
        lim = 65'(1) << (CW - 1);
        t   = mag[CW-1:0];
        if (mag >= lim) begin
            return neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return neg ? $signed(~t + 1'b1) : $signed(t);
    endfunction

    // configuration registers
    logic [rsrn_pkg::TC_W-1:0]  r_tc;
    logic [SURF_W-1:0]          r_edge;
    logic [TP_W-1:0]            r_tp;
    logic [rsrn_pkg::SQS_W-1:0] r_inner;
    logic                       r_zero;
    logic                       r_incl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc    <= rsrn_pkg::TC_W'(1);
            r_edge  <= SURF_W'(1);
            r_tp    <= TP_W'(1);
            r_inner <= rsrn_pkg::SQS_W'(65536);
            r_zero  <= 1'b0;
            r_incl  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                rsrn_pkg::CFG_TOROIDAL: r_tc    <= i_cfg_data[rsrn_pkg::TC_W-1:0];
                rsrn_pkg::CFG_EDGE:     r_edge  <= i_cfg_data[SURF_W-1:0];
                rsrn_pkg::CFG_TOTAL:    r_tp    <= i_cfg_data[TP_W-1:0];
                rsrn_pkg::CFG_INNER:    r_inner <= i_cfg_data[rsrn_pkg::SQS_W-1:0];
                rsrn_pkg::CFG_ZERO_Z:   r_zero  <= i_cfg_data[0];
                rsrn_pkg::CFG_INCL:     r_incl  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // working registers
    logic [MODE_W-1:0]          r_mode;
    logic [SURF_W-1:0]          r_surf;
    logic [rsrn_pkg::SQS_W-1:0] r_sqs;
    logic                       r_last;
    logic signed [CW-1:0]       r_c [6];
    logic [MODE_W-1:0]          r_m;
    logic [63:0]                r_rmag [2];
    logic                       r_rneg [2];
    logic [63:0]                r_prod;
    logic [63:0]                r_plo;
    logic                       r_sqsat;
    logic [63:0]                r_sum [3];
    logic [rsrn_pkg::NORM_W-1:0] r_norm [3];

    // divider operand selection
    logic [rsrn_pkg::SQS_W-1:0] dscale;
    logic [CW-1:0]              cmag;
    logic [1:0]                 gidx;
    logic [rsrn_pkg::DIV_W-1:0] dividend;
    logic [rsrn_pkg::DVS_W-1:0] divisor;
    logic                       div_done;
    logic [rsrn_pkg::DIV_W-1:0] quo;
    logic [rsrn_pkg::DVS_W-1:0] rem;

    always_comb begin
        dscale = (r_sqs > r_inner) ? r_sqs : r_inner;
        cmag   = mag_of(r_c[i_cmd.idx]);
        gidx   = i_cmd.idx[1:0];
        case (i_cmd.op)
            rsrn_pkg::OP_MODE: begin
                dividend = rsrn_pkg::DIV_W'(r_mode);
                divisor  = (r_tc == '0) ? rsrn_pkg::DVS_W'(1) : rsrn_pkg::DVS_W'(r_tc);
            end
            rsrn_pkg::OP_SCALE: begin
                dividend = (rsrn_pkg::DIV_W'(cmag) << 16) + rsrn_pkg::DIV_W'(dscale >> 1);
                divisor  = rsrn_pkg::DVS_W'(dscale);
            end
            rsrn_pkg::OP_NORM: begin
                dividend = r_sum[gidx];
                divisor  = (r_tp == '0) ? rsrn_pkg::DVS_W'(1) : rsrn_pkg::DVS_W'(r_tp);
            end
            default: begin
                dividend = '0;
                divisor  = rsrn_pkg::DVS_W'(1);
            end
        endcase
    end

    rsrn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    // norm rounding: halves up, saturate to 63 bits
    logic        rnd;
    logic [64:0] qrnd;
    logic [rsrn_pkg::NORM_W-1:0] norm_val;

    always_comb begin
        rnd      = {1'b0, rem, 1'b0} >= {2'b00, divisor};
        qrnd     = {1'b0, quo} + 65'(rnd);
        norm_val = (qrnd > 65'(rsrn_pkg::NORM_MAX)) ? rsrn_pkg::NORM_MAX
                                                   : qrnd[rsrn_pkg::NORM_W-1:0];
    end

    // rotation operands
    logic signed [CW:0] rsum;
    logic signed [CW:0] rdif;
    logic [CW:0]        rsum_u;
    logic [CW:0]        rdif_u;

    always_comb begin
        rsum   = {r_c[3][CW-1], r_c[3]} + {r_c[4][CW-1], r_c[4]};
        rdif   = {r_c[3][CW-1], r_c[3]} - {r_c[4][CW-1], r_c[4]};
        rsum_u = rsum[CW] ? (~rsum + 1'b1) : rsum;
        rdif_u = rdif[CW] ? (~rdif + 1'b1) : rdif;
    end

    // shared 32x32 multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] rop;

    always_comb begin
        rop = r_rmag[i_cmd.idx[0]];
        case (i_cmd.mul)
            rsrn_pkg::MUL_ROT_LO: begin
                mul_a = rop[31:0];
                mul_b = rsrn_pkg::INV_SQRT2_Q32;
            end
            rsrn_pkg::MUL_ROT_HI: begin
                mul_a = rop[63:32];
                mul_b = rsrn_pkg::INV_SQRT2_Q32;
            end
            rsrn_pkg::MUL_SQ: begin
                mul_a = cmag[31:0];
                mul_b = cmag[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rotated value and square accumulation
    logic [64:0] rot_val;
    logic [1:0]  sgrp;
    logic        skip;
    logic [63:0] sq_add;
    logic [64:0] acc;

    always_comb begin
        rot_val = 65'(r_prod) + 65'((r_plo + 64'h8000_0000) >> 32);
        sgrp    = (i_cmd.idx < 3'd3) ? i_cmd.idx[1:0] : 2'(i_cmd.idx - 3'd3);
        skip    = (sgrp != 2'd2) && !r_incl && (r_surf == r_edge);
        sq_add  = r_sqsat ? rsrn_pkg::SUM_MAX : r_prod;
        acc     = {1'b0, r_sum[sgrp]} + {1'b0, sq_add};
    end

    // working register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_mode <= i_mode_index;
            r_surf <= i_surface_index;
            r_sqs  <= i_sqrt_s;
            r_last <= i_last_point;
            for (int k = 0; k < 6; k++) begin
                r_c[k] <= i_comp[k];
            end
        end
        if (i_cmd.div_wr) begin
            case (i_cmd.op)
                rsrn_pkg::OP_MODE:  r_m <= quo[MODE_W-1:0];
                rsrn_pkg::OP_SCALE: r_c[i_cmd.idx] <= (cmag == '0) ? '0
                                                     : sat_mag(r_c[i_cmd.idx][CW-1], {1'b0, quo});
                default: ;
            endcase
        end
        if (i_cmd.rot_load) begin
            r_rmag[0] <= 64'(rsum_u);
            r_rneg[0] <= rsum[CW];
            r_rmag[1] <= 64'(rdif_u);
            r_rneg[1] <= rdif[CW];
        end
        if (i_cmd.mul != rsrn_pkg::MUL_NONE) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (i_cmd.mul == rsrn_pkg::MUL_ROT_HI) begin
            r_plo <= r_prod;
        end
        if (i_cmd.mul == rsrn_pkg::MUL_SQ) begin
            r_sqsat <= 64'(cmag) > 64'hFFFF_FFFF;
        end
        if (i_cmd.rot_wr) begin
            if (i_cmd.idx[0]) begin
                r_c[4] <= r_zero ? '0 : sat_mag(r_rneg[1], rot_val);
            end else begin
                r_c[3] <= sat_mag(r_rneg[0], rot_val);
            end
        end
        if (i_cmd.div_wr && i_cmd.op == rsrn_pkg::OP_NORM) begin
            r_norm[gidx] <= norm_val;
        end
    end

    // square sums: cleared at reset and after the norms are taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < 3; g++) begin
                r_sum[g] <= '0;
            end
        end else if (i_cmd.div_wr && i_cmd.op == rsrn_pkg::OP_NORM) begin
            r_sum[gidx] <= '0;
        end else if (i_cmd.sq_acc && !skip) begin
            r_sum[sgrp] <= acc[64] ? rsrn_pkg::SUM_MAX : acc[63:0];
        end
    end

    // output register
    logic r_out_valid;
    logic signed [CW-1:0] r_out_res [6];
    logic [rsrn_pkg::NORM_W-1:0] r_out_norm [3];
    logic r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int k = 0; k < 6; k++) begin
                r_out_res[k] <= r_c[k];
            end
            for (int g = 0; g < 3; g++) begin
                r_out_norm[g] <= r_last ? r_norm[g] : '0;
            end
            r_out_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out_res;
    assign o_norm      = r_out_norm;
    assign o_is_last   = r_out_last;

    // status back to the controller
    assign o_sts.div_done = div_done;
    assign o_sts.m_odd    = r_m[0];
    assign o_sts.m_one    = (r_m == MODE_W'(1));
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
endmodule

// File: rtl/rsrn_ctrl.sv
// Controller: sequences divisions, rotation, squares and norms per point.
// Depends on rsrn_pkg.
module rsrn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rsrn_pkg::t_sts  i_sts,
    output rsrn_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_GO   = 4'd1;
    localparam logic [3:0] ST_DIV_WAIT = 4'd2;
    localparam logic [3:0] ST_MCHK     = 4'd3;
    localparam logic [3:0] ST_ROT_LD   = 4'd4;
    localparam logic [3:0] ST_ROT_LO   = 4'd5;
    localparam logic [3:0] ST_ROT_HI   = 4'd6;
    localparam logic [3:0] ST_ROT_WR   = 4'd7;
    localparam logic [3:0] ST_SQ_MUL   = 4'd8;
    localparam logic [3:0] ST_SQ_ACC   = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic [2:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= rsrn_pkg::OP_MODE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_cmd.idx  = r_idx;
        o_cmd.mul  = rsrn_pkg::MUL_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_op    = rsrn_pkg::OP_MODE;
                    n_idx   = '0;
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    case (r_op)
                        rsrn_pkg::OP_MODE: n_state = ST_MCHK;
                        rsrn_pkg::OP_SCALE: begin
                            if (r_idx == 3'd5) begin
                                n_idx   = '0;
                                n_state = i_sts.m_one ? ST_ROT_LD : ST_SQ_MUL;
                            end else begin
                                n_idx   = r_idx + 3'd1;
                                n_state = ST_DIV_GO;
                            end
                        end
                        default: begin
                            if (r_idx == 3'd2) begin
                                n_state = ST_FIN;
                            end else begin
                                n_idx   = r_idx + 3'd1;
                                n_state = ST_DIV_GO;
                            end
                        end
                    endcase
                end
            end
            ST_MCHK: begin
                n_idx = '0;
                if (i_sts.m_odd) begin
                    n_op    = rsrn_pkg::OP_SCALE;
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_ROT_LD: begin
                o_cmd.rot_load = 1'b1;
                n_idx   = '0;
                n_state = ST_ROT_LO;
            end
            ST_ROT_LO: begin
                o_cmd.mul = rsrn_pkg::MUL_ROT_LO;
                n_state   = ST_ROT_HI;
            end
            ST_ROT_HI: begin
                o_cmd.mul = rsrn_pkg::MUL_ROT_HI;
                n_state   = ST_ROT_WR;
            end
            ST_ROT_WR: begin
                o_cmd.rot_wr = 1'b1;
                if (r_idx[0]) begin
                    n_idx   = '0;
                    n_state = ST_SQ_MUL;
                end else begin
                    n_idx   = 3'd1;
                    n_state = ST_ROT_LO;
                end
            end
            ST_SQ_MUL: begin
                o_cmd.mul = rsrn_pkg::MUL_SQ;
                n_state   = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_cmd.sq_acc = 1'b1;
                if (r_idx == 3'd5) begin
                    n_idx = '0;
                    if (i_sts.last) begin
                        n_op    = rsrn_pkg::OP_NORM;
                        n_state = ST_DIV_GO;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = ST_SQ_MUL;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: verif/residual_scale_rotate_norm_core_test.sv
// Self-checking test of the residual scale/rotate/norm core: random and directed
// points are predicted in-bench and compared result by result.
// Depends on rsrn_pkg, rsrn_if and the core RTL.
module residual_scale_rotate_norm_core_test;

    typedef struct packed {
        logic signed [31:0] r0, r1, r2, r3, r4, r5;
        logic [62:0]        na, nb, nc;
        logic               last;
    } t_res;

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #6 i_clk = ~i_clk;

    rsrn_cfg_if cfg_ch();
    rsrn_in_if  pt_ch();
    rsrn_out_if res_ch();

    residual_scale_rotate_norm_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg_ch), .i_in(pt_ch), .o_out(res_ch)
    );

    // predictor copy of the registers and sums
    logic [8:0]  tor_cnt;
    logic [9:0]  edge_surf;
    logic [20:0] tot_pts;
    logic [16:0] inner_s;
    logic        zero_z, incl_edge;
    logic [63:0] sq_sum [3];

    t_res  expected_q[$];
    int    fail_cnt = 0;
    int    res_cnt = 0;
    int    last_cnt = 0;
    longint cyc = 0;
    int    hold_off = 0;
    int    hold_req = 0;
    int    hold_ack = 0;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > 64'd9000000) begin
            $display("timeout at %0t", $time);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [63:0] sat32(bit neg, logic [63:0] mag);
        if (neg) return (mag >= 64'h8000_0000) ? -64'sh8000_0000 : -$signed(mag);
        return (mag >= 64'h8000_0000) ? 64'sh7FFF_FFFF : $signed(mag);
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic signed [63:0] scale_comp(logic signed [63:0] c, logic [63:0] d);
        logic [63:0] m;
        m = abs64(c);
        if (m == 0) return 0;
        if (d == 0) return sat32(c < 0, 64'hFFFF_FFFF_FFFF_FFFF);
        return sat32(c < 0, ((m << 16) + d / 2) / d);
    endfunction

    function automatic logic signed [63:0] rot_mul(logic signed [63:0] x);
        logic [63:0] m, r;
        m = abs64(x);
        r = (m >> 32) * 64'd3037000500 + (((m & 64'hFFFF_FFFF) * 64'd3037000500
            + 64'h8000_0000) >> 32);
        return sat32(x < 0, r);
    endfunction

    function automatic logic [63:0] sq_sat(logic signed [63:0] x);
        logic [63:0] m;
        m = abs64(x);
        return m > 64'hFFFF_FFFF ? 64'hFFFF_FFFF_FFFF_FFFF : m * m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return s < a ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic logic [62:0] mean_sq(logic [63:0] s, logic [63:0] dv);
        logic [63:0] q, r;
        if (dv == 0) dv = 1;
        q = s / dv;
        r = s % dv;
        if (r * 2 >= dv && r != 0) q++;
        return q > 64'h7FFF_FFFF_FFFF_FFFF ? 63'h7FFF_FFFF_FFFF_FFFF : q[62:0];
    endfunction

    // work out the result of one point and update the sums
    task automatic predict_point(logic [9:0] mode, logic [9:0] surf, logic [16:0] sqs,
                                 logic signed [31:0] cin [6], bit last);
        logic signed [63:0] c [6];
        logic signed [63:0] a, b;
        logic [63:0] dv, d, m;
        t_res e;
        for (int g = 0; g < 6; g++) c[g] = cin[g];
        dv = tor_cnt == 0 ? 1 : tor_cnt;
        m = mode / dv;
        if (m[0]) begin
            d = sqs > inner_s ? sqs : inner_s;
            for (int g = 0; g < 6; g++) c[g] = scale_comp(c[g], d);
        end
        if (m == 1) begin
            a = c[3];
            b = c[4];
            c[3] = rot_mul(a + b);
            c[4] = zero_z ? 0 : rot_mul(a - b);
        end
        for (int g = 0; g < 3; g++)
            if (!(g < 2 && !incl_edge && surf == edge_surf))
                sq_sum[g] = add_sat(sq_sum[g], add_sat(sq_sat(c[g]), sq_sat(c[g+3])));
        e = '0;
        e.r0 = c[0][31:0]; e.r1 = c[1][31:0]; e.r2 = c[2][31:0];
        e.r3 = c[3][31:0]; e.r4 = c[4][31:0]; e.r5 = c[5][31:0];
        e.last = last;
        if (last) begin
            e.na = mean_sq(sq_sum[0], tot_pts);
            e.nb = mean_sq(sq_sum[1], tot_pts);
            e.nc = mean_sq(sq_sum[2], tot_pts);
            for (int g = 0; g < 3; g++) sq_sum[g] = 0;
        end
        expected_q.push_back(e);
    endtask

    // send one point, predicting at transfer; valid drops only before a gap
    task automatic send_point(logic [9:0] mode, logic [9:0] surf, logic [16:0] sqs,
                              logic signed [31:0] cin [6], bit last, bit gaps = 1);
        int gap;
        gap = !gaps ? 0 : ($urandom_range(0, 19) == 0 ? $urandom_range(5, 60)
                                                        : $urandom_range(0, 2));
        if (gap > 0) begin
            pt_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        pt_ch.valid <= 1;
        pt_ch.mode_index <= mode;
        pt_ch.surface_index <= surf;
        pt_ch.sqrt_s <= sqs;
        pt_ch.comp_0 <= cin[0]; pt_ch.comp_1 <= cin[1]; pt_ch.comp_2 <= cin[2];
        pt_ch.comp_3 <= cin[3]; pt_ch.comp_4 <= cin[4]; pt_ch.comp_5 <= cin[5];
        pt_ch.last_point <= last;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        predict_point(mode, surf, sqs, cin, last);
    endtask

    // one register write; set_all drops valid after the last one
    task automatic write_reg(logic [rsrn_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            rsrn_pkg::CFG_TOROIDAL: tor_cnt = val[8:0];
            rsrn_pkg::CFG_EDGE:     edge_surf = val[9:0];
            rsrn_pkg::CFG_TOTAL:    tot_pts = val[20:0];
            rsrn_pkg::CFG_INNER:    inner_s = val[16:0];
            rsrn_pkg::CFG_ZERO_Z:   zero_z = val[0];
            rsrn_pkg::CFG_INCL:     incl_edge = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        pt_ch.valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic set_all(logic [8:0] t, logic [9:0] e, logic [20:0] n,
                           logic [16:0] s, bit z, bit inc);
        write_reg(rsrn_pkg::CFG_TOROIDAL, t);
        write_reg(rsrn_pkg::CFG_EDGE, e);
        write_reg(rsrn_pkg::CFG_TOTAL, n);
        write_reg(rsrn_pkg::CFG_INNER, s);
        write_reg(rsrn_pkg::CFG_ZERO_Z, z);
        write_reg(rsrn_pkg::CFG_INCL, inc);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(0, 511) - 256;
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_point(bit last, bit gaps = 1);
        logic signed [31:0] c [6];
        logic [16:0] sqs;
        logic [9:0] surf, mode;
        for (int g = 0; g < 6; g++) c[g] = rand_comp();
        sqs = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 17'h10000 : 17'h0)
                                        : 17'($urandom_range(0, 17'h1FFFF));
        surf = $urandom_range(0, 3) == 0 ? edge_surf : 10'($urandom);
        // favor m equal one and odd m
        case ($urandom_range(0, 3))
            0: mode = 10'(tor_cnt + $urandom_range(0, 3));
            default: mode = 10'($urandom);
        endcase
        send_point(mode, surf, sqs, c, last, gaps);
    endtask

    // directed extremes and special cases
    task automatic test_directed();
        logic signed [31:0] c [6];
        set_all(1, 5, 3, 17'h10000, 0, 0);
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send_point(0, 0, 0, c, 0);
        send_point(1, 5, 17'h10000, c, 0);        // m one, edge skipped
        send_point(3, 1023, 17'h1FFFF, c, 0);
        c = '{1, -1, 32'h0100_0000, 32'h8000_0000, 32'h8000_0000, 3};
        send_point(1, 1023, 17'h0, c, 0);
        send_point(1023, 5, 17'h1, c, 1);
        wait_drain();
        // zero scaling divisor, zero toroidal count, zero total points
        set_all(0, 1023, 0, 0, 1, 1);
        c = '{0, 5, -5, 32'h7FFF_FFFF, 32'h8000_0001, 0};
        send_point(1, 0, 0, c, 0);
        send_point(1, 1023, 17'h1FFFF, c, 0);
        send_point(2, 7, 17'h8000, c, 1);
        wait_drain();
        set_all(256, 1, 21'h1FFFFF, 17'h1FFFF, 0, 0);
        send_point(256, 1, 1, c, 0);
        send_point(1023, 1, 0, c, 1);
        wait_drain();
    endtask

    // random data sets under several register settings
    task automatic test_random(int count);
        int sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 1))
                set_all($urandom_range(0, 3) == 0 ? 9'd1 : 9'($urandom_range(1, 256)),
                        10'($urandom), 21'($urandom_range(1, 64)),
                        17'($urandom_range(0, 17'h1FFFF)), 1'($urandom), 1'($urandom));
            else
                set_all(9'h1FF, 0, 21'h1FFFFF, 0, 1, 1);
            for (int k = 0; k < 60 && sent < count; k++) begin
                rand_point($urandom_range(0, 11) == 0);
                sent++;
            end
            rand_point(1);
            sent++;
            wait_drain();
        end
    endtask

    // output held off while points keep coming
    task automatic test_backpressure();
        set_all(2, 3, 8, 17'h4000, 0, 1);
        hold_req++;
        for (int k = 0; k < 12; k++) rand_point(k == 11, 0);
        wait_drain();
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 0;
        else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= 800;
            res_ch.ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 0;
        end else if ($urandom_range(0, 29) == 0) begin
            hold_off <= $urandom_range(20, 150);
            res_ch.ready <= 0;
        end else
            res_ch.ready <= $urandom_range(0, 3) != 0;
    end

    // compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_res e, a;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            a = '{res_ch.res_0, res_ch.res_1, res_ch.res_2, res_ch.res_3, res_ch.res_4,
                  res_ch.res_5, res_ch.norm_a, res_ch.norm_b, res_ch.norm_c,
                  res_ch.is_last};
            res_cnt++;
            if (expected_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result %h", $time, a);
            end else begin
                e = expected_q.pop_front();
                if (a.last) last_cnt++;
                if (e.r0 != a.r0) $display("%0t: res_0 exp %h got %h", $time, e.r0, a.r0);
                if (e.r1 != a.r1) $display("%0t: res_1 exp %h got %h", $time, e.r1, a.r1);
                if (e.r2 != a.r2) $display("%0t: res_2 exp %h got %h", $time, e.r2, a.r2);
                if (e.r3 != a.r3) $display("%0t: res_3 exp %h got %h", $time, e.r3, a.r3);
                if (e.r4 != a.r4) $display("%0t: res_4 exp %h got %h", $time, e.r4, a.r4);
                if (e.r5 != a.r5) $display("%0t: res_5 exp %h got %h", $time, e.r5, a.r5);
                if (e.na != a.na) $display("%0t: norm_a exp %h got %h", $time, e.na, a.na);
                if (e.nb != a.nb) $display("%0t: norm_b exp %h got %h", $time, e.nb, a.nb);
                if (e.nc != a.nc) $display("%0t: norm_c exp %h got %h", $time, e.nc, a.nc);
                if (e.last != a.last)
                    $display("%0t: is_last exp %b got %b", $time, e.last, a.last);
                if (e != a) fail_cnt++;
            end
        end
    end

    initial begin
        cfg_ch.valid = 0; cfg_ch.addr = 0; cfg_ch.data = 0;
        pt_ch.valid = 0; pt_ch.mode_index = 0; pt_ch.surface_index = 0; pt_ch.sqrt_s = 0;
        pt_ch.comp_0 = 0; pt_ch.comp_1 = 0; pt_ch.comp_2 = 0;
        pt_ch.comp_3 = 0; pt_ch.comp_4 = 0; pt_ch.comp_5 = 0; pt_ch.last_point = 0;
        tor_cnt = 1; edge_surf = 1; tot_pts = 1; inner_s = 17'h10000;
        zero_z = 0; incl_edge = 0;
        for (int g = 0; g < 3; g++) sq_sum[g] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1800);
        wait_drain();
        $display("checked %0d results, %0d of them carrying norms, over many settings",
                 res_cnt, last_cnt);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: files.f
rtl/rsrn_pkg.sv
rtl/rsrn_if.sv
rtl/rsrn_div.sv
rtl/rsrn_dp.sv
rtl/rsrn_ctrl.sv
rtl/residual_scale_rotate_norm_core.sv
verif/residual_scale_rotate_norm_core_test.sv
